// ----- hdl/gmma_pkg.sv -----
// ----------------------------------------------------------------------------
// gmma_pkg: shared types and constants
// Command codes, register indexes, sequencer states and the token that
// travels down the cell chain of the matrix multiply-add block.
// ----------------------------------------------------------------------------
`default_nettype none
package gmma_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int IDX_W          = 3;   // row and column fields
  localparam int DIM_W          = 4;   // dimension registers
  localparam int GAIN_W         = 16;  // alpha and beta, Q8.8
  localparam int CMD_W          = 2;
  localparam int REG_W          = 3;   // register index on the config port

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A  = 2'd0,
    CMD_WR_B  = 2'd1,
    CMD_WR_C  = 2'd2,
    CMD_START = 2'd3
  } gmma_cmd_t;

  typedef enum logic [REG_W-1:0] {
    REG_ROWS  = 3'd0,
    REG_INNER = 3'd1,
    REG_COLS  = 3'd2,
    REG_ALPHA = 3'd3,
    REG_BETA  = 3'd4
  } gmma_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gmma_state_t;

  // one result position moving through the pipeline
  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } gmma_tok_t;

endpackage
`default_nettype wire

// ----- hdl/gmma_if.sv -----
// ----------------------------------------------------------------------------
// gmma_if: channel interfaces
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
interface gmma_item_if #(parameter int ELEM_WIDTH = gmma_pkg::ELEM_WIDTH_DEF);
  logic                            valid;
  logic                            ready;
  logic [gmma_pkg::CMD_W-1:0]      cmd;
  logic [gmma_pkg::IDX_W-1:0]      row_index;
  logic [gmma_pkg::IDX_W-1:0]      col_index;
  logic signed [ELEM_WIDTH-1:0]    element_value;
  modport source (output valid, cmd, row_index, col_index, element_value, input ready);
  modport sink   (input valid, cmd, row_index, col_index, element_value, output ready);
endinterface

interface gmma_result_if #(parameter int ELEM_WIDTH = gmma_pkg::ELEM_WIDTH_DEF);
  logic                            valid;
  logic                            ready;
  logic signed [ELEM_WIDTH-1:0]    result_value;
  logic [gmma_pkg::IDX_W-1:0]      result_row;
  logic [gmma_pkg::IDX_W-1:0]      result_col;
  logic                            saturated;
  logic                            last_result;
  modport source (output valid, result_value, result_row, result_col, saturated,
                  last_result, input ready);
  modport sink   (input valid, result_value, result_row, result_col, saturated,
                  last_result, output ready);
endinterface

interface gmma_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gmma_pkg::REG_W-1:0]  reg_index;
  logic [gmma_pkg::GAIN_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/gmma_cell.sv -----
// ----------------------------------------------------------------------------
// gmma_cell: one multiply-accumulate cell
// Holds column IDX of A and row IDX of B; adds its product to the partial
// sum of the token passing through and hands both to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module gmma_cell #(
  parameter int ELEM_WIDTH = gmma_pkg::ELEM_WIDTH_DEF,
  parameter int MAX_DIM    = gmma_pkg::MAX_DIM_DEF,
  parameter int SUM_W      = 2 * gmma_pkg::ELEM_WIDTH_DEF + 4,
  parameter int IDX        = 0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          wr_a,
  input  wire                          wr_b,
  input  wire [gmma_pkg::IDX_W-1:0]    wr_addr,
  input  wire signed [ELEM_WIDTH-1:0]  wr_data,
  input  wire [gmma_pkg::DIM_W-1:0]    k_dim,
  input  wire gmma_pkg::gmma_tok_t     tok_in,
  input  wire signed [SUM_W-1:0]       sum_in,
  input  wire signed [ELEM_WIDTH-1:0]  c_in,
  output gmma_pkg::gmma_tok_t          tok_out,
  output logic signed [SUM_W-1:0]      sum_out,
  output logic signed [ELEM_WIDTH-1:0] c_out
);
  import gmma_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic signed [ELEM_WIDTH-1:0]   a_col [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0]   b_row [MAX_DIM];
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [SUM_W-1:0]        contrib;

  // store column of A (by row) and row of B (by column)
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_col[wr_addr[AW-1:0]] <= wr_data;
    end
    if (wr_b) begin
      b_row[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  // product of this cell, dropped when beyond the inner size
  always_comb begin
    prod    = a_col[tok_in.row[AW-1:0]] * b_row[tok_in.col[AW-1:0]];
    contrib = (DIM_W'(IDX) < k_dim) ? SUM_W'(prod) : '0;
  end

  // advance token, partial sum and C element
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.v <= 1'b0;
    end else if (en) begin
      tok_out.v <= tok_in.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_out.row  <= tok_in.row;
      tok_out.col  <= tok_in.col;
      tok_out.last <= tok_in.last;
      sum_out      <= sum_in + contrib;
      c_out        <= c_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/gmma_scale.sv -----
// ----------------------------------------------------------------------------
// gmma_scale: alpha/beta scaling and saturation
// Five stages: two partial products of alpha times the sum, beta times C,
// the final add, then floor shift by 16 and clip to the element range.
// ----------------------------------------------------------------------------
`default_nettype none
module gmma_scale #(
  parameter int ELEM_WIDTH = gmma_pkg::ELEM_WIDTH_DEF,
  parameter int SUM_W      = 2 * gmma_pkg::ELEM_WIDTH_DEF + 4
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire gmma_pkg::gmma_tok_t       tok_in,
  input  wire signed [SUM_W-1:0]         sum_in,
  input  wire signed [ELEM_WIDTH-1:0]    c_in,
  input  wire signed [gmma_pkg::GAIN_W-1:0] alpha,
  input  wire signed [gmma_pkg::GAIN_W-1:0] beta,
  output gmma_pkg::gmma_tok_t            tok_out,
  output logic signed [ELEM_WIDTH-1:0]   value,
  output logic                           sat,
  output logic                           busy
);
  import gmma_pkg::*;

  localparam int LW  = 18;
  localparam int HW  = SUM_W - LW;
  localparam int ACW = GAIN_W + SUM_W + 1;

  gmma_tok_t t1, t2, t3, t4;
  logic signed [GAIN_W+LW:0]         plo1, plo2;
  logic signed [HW-1:0]              hi1;
  logic signed [GAIN_W+HW-1:0]       phi2;
  logic signed [ELEM_WIDTH-1:0]      c1, c2;
  logic signed [GAIN_W+ELEM_WIDTH-1:0] bc3;
  logic signed [ACW-1:0]             ab3, acc4, shifted;
  logic signed [ACW-1:0]             hi_lim, lo_lim;

  assign hi_lim = {{(ACW-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
  assign lo_lim = ~hi_lim;
  assign shifted = acc4 >>> 16;
  assign busy = t1.v | t2.v | t3.v | t4.v;

  // hold valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      t1.v <= 1'b0;
      t2.v <= 1'b0;
      t3.v <= 1'b0;
      t4.v <= 1'b0;
      tok_out.v <= 1'b0;
    end else if (en) begin
      t1.v <= tok_in.v;
      t2.v <= t1.v;
      t3.v <= t2.v;
      t4.v <= t3.v;
      tok_out.v <= t4.v;
    end
  end

  // stage datapath
  always_ff @(posedge clk) begin
    if (en) begin
      {t1.row, t1.col, t1.last} <= {tok_in.row, tok_in.col, tok_in.last};
      plo1 <= alpha * $signed({1'b0, sum_in[LW-1:0]});
      hi1  <= sum_in[SUM_W-1:LW];
      c1   <= c_in;

      {t2.row, t2.col, t2.last} <= {t1.row, t1.col, t1.last};
      phi2 <= alpha * hi1;
      plo2 <= plo1;
      c2   <= c1;

      {t3.row, t3.col, t3.last} <= {t2.row, t2.col, t2.last};
      bc3 <= beta * c2;
      ab3 <= (ACW'(phi2) <<< LW) + ACW'(plo2);

      {t4.row, t4.col, t4.last} <= {t3.row, t3.col, t3.last};
      acc4 <= ab3 + (ACW'(bc3) <<< 8);

      {tok_out.row, tok_out.col, tok_out.last} <= {t4.row, t4.col, t4.last};
      if (shifted > hi_lim) begin
        value <= hi_lim[ELEM_WIDTH-1:0];
        sat   <= 1'b1;
      end else if (shifted < lo_lim) begin
        value <= lo_lim[ELEM_WIDTH-1:0];
        sat   <= 1'b1;
      end else begin
        value <= shifted[ELEM_WIDTH-1:0];
        sat   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/general_matrix_multiply_add.sv -----
// Throughput: one result per cycle while the result channel is not stalled,
// m*n results per start; the cell chain holds one dot product step per cell.
// Words are taken only while idle with the pipeline drained. Reset clears
// control state; stores stay undefined.
// ----------------------------------------------------------------------------
// general_matrix_multiply_add: D = alpha*A*B + beta*C
// Sequencer walks results column-major into a chain of MAC cells, one per
// inner index, followed by the scaling and saturation stages.
// ----------------------------------------------------------------------------
`default_nettype none
module general_matrix_multiply_add #(
  parameter int MAX_DIM    = gmma_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = gmma_pkg::ELEM_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  gmma_item_if.sink    items,
  gmma_result_if.source results,
  gmma_cfg_if.sink     cfg
);
  import gmma_pkg::*;

  localparam int SUM_W = 2 * ELEM_WIDTH + 4;
  localparam int CD    = MAX_DIM * MAX_DIM;
  localparam int CAW   = (CD > 1) ? $clog2(CD) : 1;

  logic [DIM_W-1:0]        rows_q, inner_q, cols_q;
  logic signed [GAIN_W-1:0] alpha_q, beta_q;
  logic [DIM_W-1:0]        m_eff, k_eff, n_eff;
  gmma_state_t             state, state_next;
  logic [IDX_W-1:0]        row_cnt, col_cnt;
  logic                    row_end, col_end, issue;
  logic                    adv, busy, scale_busy, in_acc, cells_busy;
  logic                    in_range;
  gmma_tok_t               tok0;
  logic signed [ELEM_WIDTH-1:0] c_q;
  logic signed [ELEM_WIDTH-1:0] mem_c [CD];
  logic [CAW-1:0]          wr_caddr, rd_caddr;
  gmma_tok_t               tok_chain [MAX_DIM+1];
  logic signed [SUM_W-1:0] sum_chain [MAX_DIM+1];
  logic signed [ELEM_WIDTH-1:0] c_chain [MAX_DIM+1];
  logic [MAX_DIM-1:0]      cell_v;
  gmma_tok_t               tok_res;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_q  <= DIM_W'(8);
      inner_q <= DIM_W'(8);
      cols_q  <= DIM_W'(8);
      alpha_q <= GAIN_W'(256);
      beta_q  <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_ROWS:  rows_q  <= cfg.data[DIM_W-1:0];
        REG_INNER: inner_q <= cfg.data[DIM_W-1:0];
        REG_COLS:  cols_q  <= cfg.data[DIM_W-1:0];
        REG_ALPHA: alpha_q <= cfg.data;
        REG_BETA:  beta_q  <= cfg.data;
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction
  assign m_eff = clamp_dim(rows_q);
  assign k_eff = clamp_dim(inner_q);
  assign n_eff = clamp_dim(cols_q);

  // handshake and stall
  assign adv        = !results.valid || results.ready;
  assign cells_busy = |cell_v;
  assign busy       = tok0.v | cells_busy | scale_busy;
  assign items.ready = (state == ST_IDLE) && !busy;
  assign in_acc     = items.valid && items.ready;
  assign in_range   = ({1'b0, items.row_index} < (IDX_W+1)'(MAX_DIM)) &&
                      ({1'b0, items.col_index} < (IDX_W+1)'(MAX_DIM));

  // sequencer next state
  assign row_end = ({1'b0, row_cnt} == m_eff - DIM_W'(1));
  assign col_end = ({1'b0, col_cnt} == n_eff - DIM_W'(1));
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && items.cmd == CMD_START) state_next = ST_RUN;
      ST_RUN:  if (adv && row_end && col_end) state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue = 1'b0;
    unique case (state)
      ST_IDLE: issue = 1'b0;
      ST_RUN:  issue = adv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
    end else begin
      state <= state_next;
      if (issue) begin
        if (row_end) begin
          row_cnt <= '0;
          col_cnt <= col_end ? '0 : col_cnt + IDX_W'(1);
        end else begin
          row_cnt <= row_cnt + IDX_W'(1);
        end
      end
    end
  end

  // issue stage: token and C read
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0.v <= 1'b0;
    end else if (adv) begin
      tok0.v <= issue;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tok0.row  <= row_cnt;
      tok0.col  <= col_cnt;
      tok0.last <= row_end && col_end;
    end
  end

  // C store
  assign wr_caddr = CAW'(items.row_index) * CAW'(MAX_DIM) + CAW'(items.col_index);
  assign rd_caddr = CAW'(row_cnt) * CAW'(MAX_DIM) + CAW'(col_cnt);
  always_ff @(posedge clk) begin
    if (in_acc && items.cmd == CMD_WR_C && in_range) begin
      mem_c[wr_caddr] <= items.element_value;
    end
    if (adv) begin
      c_q <= mem_c[rd_caddr];
    end
  end

  // cell chain
  assign tok_chain[0] = tok0;
  assign sum_chain[0] = '0;
  assign c_chain[0]   = c_q;
  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    logic wa, wb;
    assign wa = in_acc && in_range && items.cmd == CMD_WR_A &&
                items.col_index == IDX_W'(g);
    assign wb = in_acc && in_range && items.cmd == CMD_WR_B &&
                items.row_index == IDX_W'(g);
    assign cell_v[g] = tok_chain[g+1].v;
    gmma_cell #(
      .ELEM_WIDTH(ELEM_WIDTH), .MAX_DIM(MAX_DIM), .SUM_W(SUM_W), .IDX(g)
    ) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .wr_a(wa), .wr_b(wb),
      .wr_addr(items.cmd == CMD_WR_A ? items.row_index : items.col_index),
      .wr_data(items.element_value), .k_dim(k_eff),
      .tok_in(tok_chain[g]), .sum_in(sum_chain[g]), .c_in(c_chain[g]),
      .tok_out(tok_chain[g+1]), .sum_out(sum_chain[g+1]), .c_out(c_chain[g+1])
    );
  end

  // scaling and output register
  gmma_scale #(.ELEM_WIDTH(ELEM_WIDTH), .SUM_W(SUM_W)) u_scale (
    .clk(clk), .rst(rst), .en(adv),
    .tok_in(tok_chain[MAX_DIM]), .sum_in(sum_chain[MAX_DIM]), .c_in(c_chain[MAX_DIM]),
    .alpha(alpha_q), .beta(beta_q),
    .tok_out(tok_res), .value(results.result_value), .sat(results.saturated),
    .busy(scale_busy)
  );
  assign results.valid       = tok_res.v;
  assign results.result_row  = tok_res.row;
  assign results.result_col  = tok_res.col;
  assign results.last_result = tok_res.last;

  // checks
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !items.ready) else $error("item taken during run");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    in_acc && items.cmd == CMD_START |=> state == ST_RUN)
    else $error("start did not launch run");
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !items.ready) else $error("item taken while pipeline busy");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: matrix multiply-add block
// Loads A, B and C element by element, starts runs under many dimension and
// gain settings, and checks every result word against an in-bench model of
// D = alpha*A*B + beta*C with floor shift and 16-bit saturation, or against
// the typed expected value given for a directed 1x1 start.
module testbench;
  import gmma_pkg::*;

  localparam int MAXD        = MAX_DIM_DEF;
  localparam int DRAIN       = MAXD + 7 + 8;
  localparam int RAND_ITEMS  = 230;
  localparam logic [REG_W-1:0] REG_UNUSED = 3'd5;

  typedef struct {
    logic signed [15:0] value;
    logic [2:0]         row;
    logic [2:0]         col;
    logic               sat;
    logic               last;
  } gemm_word_t;

  // one directed row: either an item word or a register write
  typedef struct {
    bit                 is_cfg;
    gmma_cmd_t          cmd;
    logic [2:0]         row;
    logic [2:0]         col;
    logic [15:0]        value;
    logic [REG_W-1:0]   reg_idx;
    logic [15:0]        data;
    bit                 typed;
    logic [15:0]        exp_value;
    logic               exp_sat;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gmma_item_if   item_ch ();
  gmma_result_if res_ch ();
  gmma_cfg_if    cfg_ch ();

  general_matrix_multiply_add dut (
    .clk(clk), .rst(rst), .items(item_ch), .results(res_ch), .cfg(cfg_ch)
  );

  always #6 clk = ~clk;

  // shadow of the block's state
  logic signed [15:0] mat_a [64];
  logic signed [15:0] mat_b [64];
  logic signed [15:0] mat_c [64];
  bit                 set_a [64];
  bit                 set_b [64];
  bit                 set_c [64];
  logic [3:0]         dim_m = 4'd8, dim_k = 4'd8, dim_n = 4'd8;
  logic signed [15:0] gain_alpha = 16'sd256, gain_beta = 16'sd0;

  gemm_word_t pending_words[$];
  int         errors = 0;
  int         rcv_hold = 0;
  bit         rcv_calm = 0;
  bit         snd_calm = 0;

  function automatic int eff_dim(logic [3:0] d);
    if (d == 0) return 1;
    if (d > MAXD) return MAXD;
    return d;
  endfunction

  // queue every result word of one start
  function automatic void predict_run();
    int m, k, n;
    longint sum, acc, res;
    gemm_word_t w;
    m = eff_dim(dim_m);
    k = eff_dim(dim_k);
    n = eff_dim(dim_n);
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < m; i++) begin
        sum = 0;
        for (int kk = 0; kk < k; kk++)
          sum += longint'(mat_a[i*8+kk]) * longint'(mat_b[kk*8+j]);
        acc = longint'(gain_alpha) * sum + longint'(gain_beta) * longint'(mat_c[i*8+j]) * 256;
        res = acc >>> 16;
        w.sat = 1'b0;
        if (res > 32767) begin
          res = 32767;
          w.sat = 1'b1;
        end
        if (res < -32768) begin
          res = -32768;
          w.sat = 1'b1;
        end
        w.value = res[15:0];
        w.row   = i[2:0];
        w.col   = j[2:0];
        w.last  = (i == m - 1) && (j == n - 1);
        pending_words.push_back(w);
      end
    end
  endfunction

  function automatic void store_word(gmma_cmd_t cmd, logic [2:0] r, logic [2:0] c,
                                     logic [15:0] v);
    int at;
    at = r * 8 + c;
    case (cmd)
      CMD_WR_A: begin
        mat_a[at] = v;
        set_a[at] = 1;
      end
      CMD_WR_B: begin
        mat_b[at] = v;
        set_b[at] = 1;
      end
      CMD_WR_C: begin
        mat_c[at] = v;
        set_c[at] = 1;
      end
      default: predict_run();
    endcase
  endfunction

  // hand one word to the block after a random gap
  task automatic send_word(gmma_cmd_t cmd, logic [2:0] r, logic [2:0] c, logic [15:0] v,
                           bit typed, logic [15:0] ev, logic es);
    int gap;
    gemm_word_t w;
    gap = snd_calm ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.cmd           <= cmd;
    item_ch.row_index     <= r;
    item_ch.col_index     <= c;
    item_ch.element_value <= v;
    item_ch.valid         <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    if (typed && cmd == CMD_START) begin
      w.value = ev;
      w.row   = 3'd0;
      w.col   = 3'd0;
      w.sat   = es;
      w.last  = 1'b1;
      pending_words.push_back(w);
    end else begin
      store_word(cmd, r, c, v);
    end
  endtask

  // hold off until every result is in and the pipeline has drained
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= d;
    cfg_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ROWS:  dim_m = d[3:0];
      REG_INNER: dim_k = d[3:0];
      REG_COLS:  dim_n = d[3:0];
      REG_ALPHA: gain_alpha = d;
      REG_BETA:  gain_beta = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    logic [3:0] d;
    case ($urandom_range(0, 9))
      0: d = 4'd0;
      1: d = 4'd8;
      2: d = 4'd15;
      3: d = 4'($urandom_range(0, 15));
      default: d = 4'($urandom_range(1, 3));
    endcase
    return {12'($urandom()), d};
  endfunction

  // load every entry the next start will read that is still unwritten
  task automatic fill_missing();
    int m, k, n;
    m = eff_dim(dim_m);
    k = eff_dim(dim_k);
    n = eff_dim(dim_n);
    for (int i = 0; i < m; i++)
      for (int kk = 0; kk < k; kk++)
        if (!set_a[i*8+kk]) send_word(CMD_WR_A, 3'(i), 3'(kk), pick_value(), 0, 0, 0);
    for (int kk = 0; kk < k; kk++)
      for (int j = 0; j < n; j++)
        if (!set_b[kk*8+j]) send_word(CMD_WR_B, 3'(kk), 3'(j), pick_value(), 0, 0, 0);
    for (int i = 0; i < m; i++)
      for (int j = 0; j < n; j++)
        if (!set_c[i*8+j]) send_word(CMD_WR_C, 3'(i), 3'(j), pick_value(), 0, 0, 0);
  endtask

  // directed rows: 1x1 extremes with typed results, then gain and dimension corners
  step_row_t plan[$] = '{
    '{1, CMD_START, 0, 0, 0, REG_ROWS,   16'h0001, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_INNER,  16'h0001, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_COLS,   16'h0001, 0, 0, 0},
    '{0, CMD_WR_A,  0, 0, 16'h0100, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_WR_B,  0, 0, 16'h0100, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_WR_C,  0, 0, 16'h0000, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_START, 0, 0, 0, REG_ROWS, 0, 1, 16'h0100, 1'b0},
    '{0, CMD_WR_A,  0, 0, 16'h7fff, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_WR_B,  0, 0, 16'h7fff, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_START, 0, 0, 0, REG_ROWS, 0, 1, 16'h7fff, 1'b1},
    '{0, CMD_WR_A,  0, 0, 16'h8000, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_START, 0, 0, 0, REG_ROWS, 0, 1, 16'h8000, 1'b1},
    '{1, CMD_START, 0, 0, 0, REG_ALPHA,  16'h7fff, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_BETA,   16'h8000, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_UNUSED, 16'h1234, 0, 0, 0},
    '{0, CMD_WR_C,  0, 0, 16'h8000, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_START, 0, 0, 0, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_WR_B,  0, 0, 16'hffff, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_WR_C,  0, 0, 16'h7fff, REG_ROWS, 0, 0, 0, 0},
    '{0, CMD_START, 0, 0, 0, REG_ROWS, 0, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_ROWS,   16'hfff0, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_ALPHA,  16'h8000, 0, 0, 0},
    '{1, CMD_START, 0, 0, 0, REG_BETA,   16'h7fff, 0, 0, 0},
    '{0, CMD_START, 0, 0, 0, REG_ROWS, 0, 0, 0, 0}
  };

  // stimulus
  initial begin
    int sent;
    int burst;
    gmma_cmd_t c;
    logic [2:0] r, cc;
    item_ch.valid = 0;
    item_ch.cmd = CMD_WR_A;
    item_ch.row_index = 0;
    item_ch.col_index = 0;
    item_ch.element_value = 0;
    cfg_ch.valid = 0;
    cfg_ch.reg_index = REG_ROWS;
    cfg_ch.data = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[p]) begin
      if (plan[p].is_cfg) begin
        wait_drained();
        write_reg(plan[p].reg_idx, plan[p].data);
      end else begin
        send_word(plan[p].cmd, plan[p].row, plan[p].col, plan[p].value,
                  plan[p].typed, plan[p].exp_value, plan[p].exp_sat);
      end
    end

    // random phases: new settings, fill what is needed, then mixed words
    sent = 0;
    while (sent < RAND_ITEMS) begin
      wait_drained();
      snd_calm = ($urandom_range(0, 3) == 0);
      rcv_calm = ($urandom_range(0, 3) == 0);
      write_reg(REG_ROWS, pick_dim());
      write_reg(REG_INNER, pick_dim());
      write_reg(REG_COLS, pick_dim());
      write_reg(REG_ALPHA, ($urandom_range(0, 2) == 0) ? pick_value()
                           : 16'($urandom_range(0, 512)) - 16'd256);
      write_reg(REG_BETA, ($urandom_range(0, 2) == 0) ? pick_value()
                          : 16'($urandom_range(0, 512)) - 16'd256);
      if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(5, 7)), 16'($urandom()));
      fill_missing();
      burst = $urandom_range(4, 20);
      for (int b = 0; b < burst; b++) begin
        if (b == burst - 1 || $urandom_range(0, 4) == 0) begin
          c = CMD_START;
        end else begin
          c = gmma_cmd_t'($urandom_range(0, 2));
        end
        if ($urandom_range(0, 3) == 0) begin
          r = 3'($urandom());
          cc = 3'($urandom());
        end else begin
          r = 3'($urandom_range(0, eff_dim(dim_m) - 1));
          cc = 3'($urandom_range(0, eff_dim(dim_n) - 1));
        end
        send_word(c, r, cc, (c == CMD_START) ? 16'($urandom()) : pick_value(), 0, 0, 0);
        sent++;
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: random stalls between words
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rcv_hold > 0) begin
        res_ch.ready <= 1'b0;
        rcv_hold--;
      end else begin
        res_ch.ready <= !rst;
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    gemm_word_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      rcv_hold = rcv_calm ? 0 : $urandom_range(0, 9);
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word value %h row %0d col %0d", $time,
                 res_ch.result_value, res_ch.result_row, res_ch.result_col);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (res_ch.result_value !== w.value || res_ch.result_row !== w.row ||
            res_ch.result_col !== w.col || res_ch.saturated !== w.sat ||
            res_ch.last_result !== w.last) begin
          $display("%0t: expected val %h r %0d c %0d sat %b last %b, got %h r %0d c %0d sat %b last %b",
                   $time, w.value, w.row, w.col, w.sat, w.last, res_ch.result_value,
                   res_ch.result_row, res_ch.result_col, res_ch.saturated, res_ch.last_result);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gmma_pkg.sv
hdl/gmma_if.sv
hdl/gmma_cell.sv
hdl/gmma_scale.sv
hdl/general_matrix_multiply_add.sv
tb/testbench.sv
